// File: design/alist_pkg.sv
`timescale 1ns / 1ps
// alist_pkg: shared types and constants for the array list engine.
// No dependencies; imported by every module of the block.
package alist_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VALUE_W      = 32;
	localparam int OP_W         = 2;
	localparam int POS_W        = 5;
	localparam int STATUS_W     = 2;
	localparam int FIDX_W       = 4;
	localparam int COUNT_W      = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_SORTED = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BADPOS   = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_LEFT  = 2'd2,
		CELL_RIGHT = 2'd3
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_CMP   = 2'd1,
		S_APPLY = 2'd2
	} state_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  value;
		logic [POS_W-1:0]           position;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [FIDX_W-1:0]    found_index;
		logic [COUNT_W-1:0]   entry_count;
	} res_t;

endpackage

// File: design/alist_req_if.sv
`timescale 1ns / 1ps
// alist_req_if: request channel, one transaction per list request.
// Depends on alist_pkg for field widths.
interface alist_req_if import alist_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            op;
	logic signed [VALUE_W-1:0]  value;
	logic [POS_W-1:0]           position;

	modport source (output valid, op, value, position, input ready);
	modport sink   (input valid, op, value, position, output ready);
endinterface

// File: design/alist_res_if.sv
`timescale 1ns / 1ps
// alist_res_if: result channel, one transaction per completed request.
// Depends on alist_pkg for field widths.
interface alist_res_if import alist_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [STATUS_W-1:0]        status;
	logic [FIDX_W-1:0]          found_index;
	logic [COUNT_W-1:0]         entry_count;

	modport source (output valid, status, found_index, entry_count, input ready);
	modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

// File: design/alist_cell.sv
`timescale 1ns / 1ps
// alist_cell: one list entry with its key comparator and neighbour shift mux.
// Depends on alist_pkg.
module alist_cell import alist_pkg::*; (
	input  logic                       clk,
	input  logic signed [VALUE_W-1:0]  key,
	input  logic signed [VALUE_W-1:0]  left_val,
	input  logic signed [VALUE_W-1:0]  right_val,
	input  cell_cmd_t                  cmd,
	input  logic                       cmp_en,
	output logic signed [VALUE_W-1:0]  value,
	output logic                       eq,
	output logic                       gt
);

	logic signed [VALUE_W-1:0] value_q;
	logic                      eq_q;
	logic                      gt_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CELL_LOAD:  value_q <= key;
			CELL_LEFT:  value_q <= left_val;
			CELL_RIGHT: value_q <= right_val;
			default:    value_q <= value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			eq_q <= (value_q == key);
			gt_q <= (value_q > key);
		end
	end

	assign value = value_q;
	assign eq    = eq_q;
	assign gt    = gt_q;

endmodule

// File: design/alist_find.sv
`timescale 1ns / 1ps
// alist_find: search over the cell compare flags, masked to occupied cells.
// Depends on alist_pkg.
module alist_find import alist_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic [CAPACITY-1:0]  eq_flags,
	input  logic [CAPACITY-1:0]  gt_flags,
	input  logic [CNT_W-1:0]     count,
	output logic                 hit,
	output logic [IDX_W-1:0]     last_eq,
	output logic                 gt_any,
	output logic [IDX_W-1:0]     first_gt,
	output logic                 last_ge
);

	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] eq_m;
	logic [CAPACITY-1:0] gt_m;
	logic [CNT_W-1:0]    last_pos;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occ[i] = (CNT_W'(i) < count);
		end
	end

	assign eq_m     = eq_flags & occ;
	assign gt_m     = gt_flags & occ;
	assign hit      = |eq_m;
	assign gt_any   = |gt_m;
	assign last_pos = count - CNT_W'(1);
	assign last_ge  = (count != '0) &&
		(eq_flags[last_pos[IDX_W-1:0]] || gt_flags[last_pos[IDX_W-1:0]]);

	always_comb begin
		last_eq = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq_m[i]) begin
				last_eq = IDX_W'(i);
			end
		end
	end

	always_comb begin
		first_gt = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (gt_m[i]) begin
				first_gt = IDX_W'(i);
			end
		end
	end

endmodule

// File: design/array_list_engine.sv
`timescale 1ns / 1ps
// array_list_engine: fixed-capacity list of signed 32-bit values.
// Depends on alist_pkg, alist_req_if, alist_res_if, alist_cell, alist_find.
//
// Usage:
//   req carries one transaction per request: op (insert at position,
//   delete at position, locate, sorted insert), value and position.
//   res returns exactly one transaction per request: status, found_index
//   and the entry count after the request.
//   Each entry lives in its own cell; all cells shift to their neighbours
//   together, so inserts and deletes move the whole list at once.
//   Sequence: the request is registered on acceptance, the cell compares
//   are registered in the compare state, and the update state updates the
//   cells and loads the result register. One request is in flight at a
//   time, so a new request is taken only after the last one is updated.
//   If the receiver stalls, the result is held in the output register and
//   the next request waits in its update cycle until the result is taken.
//   Reset empties the list (count zero); entry contents are not cleared
//   and no clearing pass is needed.
module array_list_engine import alist_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	alist_req_if.sink      req,
	alist_res_if.source    res
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	state_t                     state_q;
	state_t                     state_nx;
	req_t                       req_s1;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           count_nx;
	logic                       out_valid_q;
	res_t                       out_q;
	res_t                       out_nx;

	logic                       req_ready;
	logic                       cmp_en;
	logic                       apply_go;

	logic signed [VALUE_W-1:0]  vals [CAPACITY];
	logic [CAPACITY-1:0]        eq_flags;
	logic [CAPACITY-1:0]        gt_flags;
	cell_cmd_t                  cmds [CAPACITY];

	logic                       hit;
	logic [IDX_W-1:0]           last_eq;
	logic                       gt_any;
	logic [IDX_W-1:0]           first_gt;
	logic                       last_ge;

	logic                       full;
	logic [CW-1:0]              pos_ext;
	logic [CW-1:0]              cnt_ext;
	logic [CNT_W-1:0]           ins_at;
	logic [CNT_W-1:0]           sort_at;
	logic [CNT_W-1:0]           put_at;
	logic                       do_put;
	logic                       do_del;

	// cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VALUE_W-1:0] left_v;
		logic signed [VALUE_W-1:0] right_v;
		if (g == 0) begin : g_first
			assign left_v = req_s1.value;
		end else begin : g_mid
			assign left_v = vals[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_v = req_s1.value;
		end else begin : g_body
			assign right_v = vals[g+1];
		end
		alist_cell u_cell (
			.clk       (clk),
			.key       (req_s1.value),
			.left_val  (left_v),
			.right_val (right_v),
			.cmd       (cmds[g]),
			.cmp_en    (cmp_en),
			.value     (vals[g]),
			.eq        (eq_flags[g]),
			.gt        (gt_flags[g])
		);
	end

	alist_find #(.CAPACITY(CAPACITY)) u_find (
		.eq_flags (eq_flags),
		.gt_flags (gt_flags),
		.count    (count_q),
		.hit      (hit),
		.last_eq  (last_eq),
		.gt_any   (gt_any),
		.first_gt (first_gt),
		.last_ge  (last_ge)
	);

	// request decode
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign pos_ext = CW'(req_s1.position);
	assign cnt_ext = CW'(count_q);
	assign ins_at  = (pos_ext > cnt_ext) ? count_q : CNT_W'(req_s1.position);
	assign sort_at = (last_ge && gt_any) ? CNT_W'(first_gt) : count_q;
	assign put_at  = (req_s1.op == OP_SORTED) ? sort_at : ins_at;
	assign do_put  = ((req_s1.op == OP_INSERT) || (req_s1.op == OP_SORTED)) && !full;
	assign do_del  = (req_s1.op == OP_DELETE) && (pos_ext < cnt_ext);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cmds[i] = CELL_HOLD;
			if (apply_go) begin
				if (do_put) begin
					if (CNT_W'(i) == put_at) begin
						cmds[i] = CELL_LOAD;
					end else if (CNT_W'(i) > put_at) begin
						cmds[i] = CELL_LEFT;
					end
				end else if (do_del && (CW'(i) >= pos_ext)) begin
					cmds[i] = CELL_RIGHT;
				end
			end
		end
	end

	always_comb begin
		count_nx           = count_q;
		out_nx.status      = ST_OK;
		out_nx.found_index = '0;
		unique case (req_s1.op)
			OP_INSERT, OP_SORTED: begin
				if (full) begin
					out_nx.status = ST_FULL;
				end else begin
					count_nx = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (do_del) begin
					count_nx = count_q - CNT_W'(1);
				end else begin
					out_nx.status = ST_BADPOS;
				end
			end
			OP_LOCATE: begin
				if (hit) begin
					out_nx.found_index = FIDX_W'(last_eq);
				end else begin
					out_nx.status = ST_NOTFOUND;
				end
			end
			default: begin
				out_nx.status = ST_OK;
			end
		endcase
		out_nx.entry_count = COUNT_W'(count_nx);
	end

	// control
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (req.valid) state_nx = S_CMP;
			S_CMP:   state_nx = S_APPLY;
			S_APPLY: if (!out_valid_q || res.ready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmp_en    = 1'b0;
		apply_go  = 1'b0;
		unique case (state_q)
			S_IDLE:  req_ready = 1'b1;
			S_CMP:   cmp_en = 1'b1;
			S_APPLY: apply_go = !out_valid_q || res.ready;
			default: req_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (apply_go) begin
				count_q     <= count_nx;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			req_s1.op       <= op_t'(req.op);
			req_s1.value    <= req.value;
			req_s1.position <= req.position;
		end
		if (apply_go) begin
			out_q <= out_nx;
		end
	end

	assign req.ready       = req_ready;
	assign res.valid       = out_valid_q;
	assign res.status      = out_q.status;
	assign res.found_index = out_q.found_index;
	assign res.entry_count = out_q.entry_count;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_CMP))
		else $error("accepted request did not enter compare");

	a_result_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == S_APPLY))
		else $error("result raised outside update cycle");

	a_count_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(apply_go))
		else $error("count changed outside update cycle");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.status == ST_FULL)) |-> full)
		else $error("full status with free entries");

endmodule

// File: tb/sv/alist_checker.sv
`timescale 1ns / 1ps
// alist_checker: watches the request and result channels of the array list engine,
// keeps its own copy of the list to predict each result and compares field by field.
// Depends on alist_pkg, alist_req_if and alist_res_if.
module alist_checker import alist_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic   clk,
	input  logic   arst_n,
	alist_req_if   req,
	alist_res_if   res,
	output int     fail_count,
	output int     pending
);

	logic signed [VALUE_W-1:0] list_vals [CAPACITY];
	int unsigned               list_len;
	res_t                      awaited_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
		list_len   = 0;
		foreach (list_vals[i]) list_vals[i] = '0;
	end

	function automatic status_t put_value(logic signed [VALUE_W-1:0] v, int unsigned at);
		if (list_len >= CAPACITY)
			return ST_FULL;
		if (at > list_len)
			at = list_len;
		for (int unsigned i = list_len; i > at; i--)
			list_vals[i] = list_vals[i-1];
		list_vals[at] = v;
		list_len++;
		return ST_OK;
	endfunction

	function automatic res_t apply_request(op_t op, logic signed [VALUE_W-1:0] v,
			logic [POS_W-1:0] pos);
		res_t        r;
		int unsigned where;
		bit          hit;
		r.status      = ST_OK;
		r.found_index = '0;
		hit           = 1'b0;
		case (op)
			OP_INSERT: begin
				r.status = put_value(v, pos);
			end
			OP_DELETE: begin
				if (pos >= list_len) begin
					r.status = ST_BADPOS;
				end else begin
					for (int unsigned i = pos; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
				end
			end
			OP_LOCATE: begin
				for (int unsigned i = 0; i < list_len; i++) begin
					if (list_vals[i] == v) begin
						hit           = 1'b1;
						r.found_index = i[FIDX_W-1:0];
					end
				end
				if (!hit)
					r.status = ST_NOTFOUND;
			end
			default: begin
				where = list_len;
				if (list_len > 0 && v <= list_vals[list_len-1]) begin
					for (int unsigned i = 0; i < list_len; i++) begin
						if (v < list_vals[i]) begin
							where = i;
							break;
						end
					end
				end
				r.status = put_value(v, where);
			end
		endcase
		r.entry_count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			list_len = 0;
			awaited_q.delete();
			pending <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (awaited_q.size() == 0) begin
					$error("result transaction with no request outstanding");
					fail_count++;
				end else begin
					want = awaited_q.pop_front();
					if (res.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, res.status);
						fail_count++;
					end
					if (res.found_index !== want.found_index) begin
						$error("found_index: expected %0d, actual %0d",
							want.found_index, res.found_index);
						fail_count++;
					end
					if (res.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							want.entry_count, res.entry_count);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_q.push_back(apply_request(op_t'(req.op), req.value, req.position));
			pending <= awaited_q.size();
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives directed and random list requests into array_list_engine with
// bursty requests and a stalling receiver; alist_checker predicts and compares.
// Depends on alist_pkg, alist_req_if, alist_res_if, alist_checker and the block.
module testbench;
	import alist_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int HOLD_START   = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	alist_req_if req_ch ();
	alist_res_if res_ch ();

	array_list_engine #(.CAPACITY(DEF_CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	alist_checker #(.CAPACITY(DEF_CAPACITY)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	task automatic send_req(op_t op, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] pos);
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.value    <= v;
		req_ch.position <= pos;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// small pool so that locates hit and duplicates build up
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return int'($urandom_range(0, 6)) - 3;
		else if (r < 70)
			return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		else
			return $urandom();
	endfunction

	function automatic op_t pick_op(bit filling);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (filling) begin
			if (r < 35) return OP_INSERT;
			if (r < 70) return OP_SORTED;
			if (r < 80) return OP_DELETE;
			return OP_LOCATE;
		end
		if (r < 10) return OP_INSERT;
		if (r < 20) return OP_SORTED;
		if (r < 70) return OP_DELETE;
		return OP_LOCATE;
	endfunction

	// receiver: random segments of ready patterns, one long hold-off
	initial begin
		int  cyc;
		int  mode;
		int  len;
		bit  held;
		cyc  = 0;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(4, 40);
			repeat (len) begin
				@(posedge clk);
				cyc++;
				if (!held && cyc >= HOLD_START) begin
					res_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					held = 1'b1;
				end
				case (mode)
					0:       res_ch.ready <= 1'b1;
					1:       res_ch.ready <= 1'($urandom_range(0, 1));
					2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
					default: res_ch.ready <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	initial begin
		int  sent;
		int  burst;
		int  gap;
		bit  paused;
		logic [POS_W-1:0] pos;
		sent   = 0;
		paused = 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.op       <= OP_INSERT;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		wait (arst_n);
		@(posedge clk);

		// directed: empty list, sorted edges, append on far positions, full list
		send_req(OP_DELETE, 0, 0);
		send_req(OP_LOCATE, 5, 0);
		send_req(OP_SORTED, 10, 0);
		send_req(OP_SORTED, 10, 0);
		send_req(OP_SORTED, VAL_MIN, 0);
		send_req(OP_SORTED, VAL_MAX, 0);
		send_req(OP_SORTED, 3, 0);
		send_req(OP_INSERT, -1, 31);
		send_req(OP_INSERT, 0, 0);
		send_req(OP_INSERT, 7, 16);
		send_req(OP_LOCATE, 10, 0);
		send_req(OP_LOCATE, 12345, 0);
		send_req(OP_DELETE, 0, 7);
		send_req(OP_DELETE, 0, 7);
		send_req(OP_DELETE, 0, 0);
		for (int i = 0; i < 10; i++)
			send_req(OP_INSERT, pick_value(), POS_W'($urandom_range(0, 31)));
		send_req(OP_INSERT, 1, 0);
		send_req(OP_SORTED, 1, 0);
		send_req(OP_DELETE, 0, 16);
		drain_results();

		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(0, 9) < 7)
					pos = POS_W'($urandom_range(0, DEF_CAPACITY + 1));
				else
					pos = POS_W'($urandom());
				send_req(pick_op(((sent / 40) % 2) == 0), pick_value(), pos);
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					req_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		req_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
